// ===== rtl/spm_pkg.sv =====
// ----------------------------------------------------------------------------
// spm_pkg
// shared types and constants of the sparse polynomial multiplier
// ----------------------------------------------------------------------------
package spm_pkg;

    localparam int TERM_COEF_W       = 16;
    localparam int TERM_EXP_W        = 10;
    localparam int COEF_W            = 40;
    localparam int PEXP_W            = 11;
    localparam int PRODUCT_SLOTS     = 64;
    localparam int MAX_TERMS_A_DEF   = 8;
    localparam int MAX_TERMS_B_DEF   = 8;
    localparam int EXP_BITS_DEF      = 10;

    localparam logic [1:0] MODE_LOAD_A = 2'd0;
    localparam logic [1:0] MODE_LOAD_B = 2'd1;
    localparam logic [1:0] MODE_START  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MULT,
        ST_FLUSH,
        ST_DRAIN
    } spm_state_t;

    // one stored product term
    typedef struct packed {
        logic              valid;
        logic [PEXP_W-1:0] expo;
        logic [COEF_W-1:0] coef;
    } spm_entry_t;

    // product term travelling down the chain
    typedef struct packed {
        logic              valid;
        logic              no_swap;
        logic [PEXP_W-1:0] expo;
        logic [COEF_W-1:0] coef;
    } spm_item_t;

    // chain-wide control
    typedef struct packed {
        logic clear;
        logic shift;
    } spm_ctrl_t;

endpackage

// ===== rtl/spm_cell.sv =====
// ----------------------------------------------------------------------------
// spm_cell
// one slot of the sorted product table, systolic insert and left shift drain
// ----------------------------------------------------------------------------
module spm_cell
    import spm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  spm_ctrl_t  ctrl,
    input  spm_item_t  item_in,
    input  spm_entry_t right_ent,
    output spm_item_t  item_out,
    output spm_entry_t ent
);

    spm_entry_t ent_reg, ent_next;
    spm_item_t  itm_reg, itm_next;

    always_comb
    begin
        ent_next       = ent_reg;
        itm_next       = item_in;
        itm_next.valid = 1'b0;
        if (ctrl.clear)
        begin
            ent_next.valid = 1'b0;
        end
        else if (ctrl.shift)
        begin
            ent_next = right_ent;
        end
        else if (item_in.valid)
        begin
            if (!ent_reg.valid)
            begin
                ent_next = '{valid: 1'b1, expo: item_in.expo, coef: item_in.coef};
            end
            else if (ent_reg.expo == item_in.expo)
            begin
                ent_next.coef = ent_reg.coef + item_in.coef;
            end
            else if ((ent_reg.expo > item_in.expo) || item_in.no_swap)
            begin
                // pass the item on
                itm_next = item_in;
            end
            else
            begin
                // take the item, push own entry down
                ent_next = '{valid: 1'b1, expo: item_in.expo, coef: item_in.coef};
                itm_next = '{valid: 1'b1, no_swap: 1'b0,
                             expo: ent_reg.expo, coef: ent_reg.coef};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_reg <= '0;
            itm_reg <= '0;
        end
        else
        begin
            ent_reg <= ent_next;
            itm_reg <= itm_next;
        end
    end

    assign item_out = itm_reg;
    assign ent      = ent_reg;

endmodule

// ===== rtl/sparse_polynomial_multiplier_core.sv =====
// ----------------------------------------------------------------------------
// sparse_polynomial_multiplier_core
// multiplies two loaded sparse polynomials and streams the product terms
// ----------------------------------------------------------------------------
// terms of a and b are loaded one item each. a start item walks every pair of
// terms through a registered 16x16 multiplier, one pair a cycle for the first
// 64 pairs, into a row of 64 cells that keeps the product sorted by descending
// exponent: a product travels down the row one cell a cycle, merging with an
// equal exponent or displacing a smaller one. once 64 pairs have been issued
// each further pair waits for the row to settle. then the row is shifted out
// one cell a cycle while the output can take terms, zero terms skipped, highest
// exponent first. a term waits in the pending register until the output register
// is free; zero terms are shifted out even while it waits.
// ----------------------------------------------------------------------------
module sparse_polynomial_multiplier_core
    import spm_pkg::*;
#(
    parameter int MAX_TERMS_A = MAX_TERMS_A_DEF,
    parameter int MAX_TERMS_B = MAX_TERMS_B_DEF,
    parameter int EXP_BITS    = EXP_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // term_coef[15:0], term_exponent[25:16], zero pad
    input  logic [1:0]  s_tuser,   // mode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // result_coef[39:0], result_exponent[50:40], zero pad
    output logic        m_tlast,   // last_term
    output logic [1:0]  m_tuser    // empty_product[0], load_overflow[1]
);

    localparam int CA       = $clog2(MAX_TERMS_A + 1);
    localparam int CB       = $clog2(MAX_TERMS_B + 1);
    localparam int IA       = (MAX_TERMS_A > 1) ? $clog2(MAX_TERMS_A) : 1;
    localparam int IB       = (MAX_TERMS_B > 1) ? $clog2(MAX_TERMS_B) : 1;
    localparam int ISS_W    = $clog2(PRODUCT_SLOTS + 1);
    localparam int QUIET_W  = $clog2(PRODUCT_SLOTS + 3);
    localparam int EB       = (EXP_BITS < TERM_EXP_W) ? EXP_BITS : TERM_EXP_W;
    localparam logic [TERM_EXP_W-1:0] EXP_MASK = TERM_EXP_W'((1 << EB) - 1);
    localparam logic [QUIET_W-1:0]    QUIET_LOAD = QUIET_W'(PRODUCT_SLOTS + 2);

    // input unpacking
    logic [1:0]             in_mode;
    logic [TERM_COEF_W-1:0] in_coef;
    logic [TERM_EXP_W-1:0]  in_exp;
    logic                   in_acc;

    assign in_mode = s_tuser;
    assign in_coef = s_tdata[TERM_COEF_W-1:0];
    assign in_exp  = s_tdata[TERM_COEF_W +: TERM_EXP_W] & EXP_MASK;
    assign in_acc  = s_tvalid && s_tready;

    // term stores
    logic [TERM_COEF_W-1:0] a_coefs_reg [MAX_TERMS_A];
    logic [TERM_EXP_W-1:0]  a_exps_reg  [MAX_TERMS_A];
    logic [TERM_COEF_W-1:0] b_coefs_reg [MAX_TERMS_B];
    logic [TERM_EXP_W-1:0]  b_exps_reg  [MAX_TERMS_B];

    spm_state_t         state_reg, state_next;
    logic [CA-1:0]      a_count_reg, a_count_next;
    logic [CB-1:0]      b_count_reg, b_count_next;
    logic [CA-1:0]      i_reg, i_next;
    logic [CB-1:0]      j_reg, j_next;
    logic [ISS_W-1:0]   issued_reg, issued_next;
    logic [QUIET_W-1:0] quiet_reg, quiet_next;
    logic               ovf_reg, ovf_next;

    // multiplier stage
    logic                          mul_v_reg, mul_v_next;
    logic                          mul_nos_reg, mul_nos_next;
    logic signed [2*TERM_COEF_W-1:0] mul_p_reg;
    logic [PEXP_W-1:0]             mul_e_reg;

    // pending term and output register
    logic              pend_have_reg, pend_have_next;
    spm_entry_t        pend_reg, pend_next;
    logic              out_v_reg, out_v_next;
    logic [COEF_W-1:0] out_coef_reg, out_coef_next;
    logic [PEXP_W-1:0] out_exp_reg, out_exp_next;
    logic              out_last_reg, out_last_next;
    logic              out_empty_reg, out_empty_next;
    logic              out_ovf_reg, out_ovf_next;

    // cell row
    spm_ctrl_t  ctrl;
    spm_item_t  chain_item [PRODUCT_SLOTS+1];
    spm_entry_t chain_ent  [PRODUCT_SLOTS+1];

    assign chain_item[0] = '{valid: mul_v_reg, no_swap: mul_nos_reg, expo: mul_e_reg,
                             coef: COEF_W'(mul_p_reg)};
    assign chain_ent[PRODUCT_SLOTS] = '0;

    genvar g;
    generate
        for (g = 0; g < PRODUCT_SLOTS; g++)
        begin : g_cell
            spm_entry_t ent_w;
            spm_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (ctrl),
                .item_in  (chain_item[g]),
                .right_ent(chain_ent[g+1]),
                .item_out (chain_item[g+1]),
                .ent      (ent_w)
            );
            assign chain_ent[g] = ent_w;
        end
    endgenerate

    logic out_free;
    logic issue_ok;
    logic do_issue;

    assign out_free = !out_v_reg || m_tready;
    assign issue_ok = (issued_reg < ISS_W'(PRODUCT_SLOTS)) || (quiet_reg == '0);
    assign do_issue = (state_reg == ST_MULT) && issue_ok;
    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        a_count_next   = a_count_reg;
        b_count_next   = b_count_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        issued_next    = issued_reg;
        quiet_next     = (quiet_reg != '0) ? quiet_reg - 1'b1 : quiet_reg;
        ovf_next       = ovf_reg;
        mul_v_next     = 1'b0;
        mul_nos_next   = 1'b0;
        pend_have_next = pend_have_reg;
        pend_next      = pend_reg;
        out_v_next     = out_v_reg && !m_tready;
        out_coef_next  = out_coef_reg;
        out_exp_next   = out_exp_reg;
        out_last_next  = out_last_reg;
        out_empty_next = out_empty_reg;
        out_ovf_next   = out_ovf_reg;
        ctrl           = '{clear: 1'b0, shift: 1'b0};

        // a product fell off the end of a full row
        if (chain_item[PRODUCT_SLOTS].valid)
        begin
            ovf_next = 1'b1;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    case (in_mode)
                        MODE_LOAD_A:
                        begin
                            if (a_count_reg < CA'(MAX_TERMS_A))
                                a_count_next = a_count_reg + 1'b1;
                            else
                                ovf_next = 1'b1;
                        end
                        MODE_LOAD_B:
                        begin
                            if (b_count_reg < CB'(MAX_TERMS_B))
                                b_count_next = b_count_reg + 1'b1;
                            else
                                ovf_next = 1'b1;
                        end
                        MODE_START:
                        begin
                            ctrl.clear     = 1'b1;
                            i_next         = '0;
                            j_next         = '0;
                            issued_next    = '0;
                            pend_have_next = 1'b0;
                            if ((a_count_reg == '0) || (b_count_reg == '0))
                                state_next = ST_FLUSH;
                            else
                                state_next = ST_MULT;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_MULT:
            begin
                if (issue_ok)
                begin
                    mul_v_next   = 1'b1;
                    mul_nos_next = (issued_reg >= ISS_W'(PRODUCT_SLOTS)) &&
                                   chain_ent[PRODUCT_SLOTS-1].valid;
                    if (issued_reg < ISS_W'(PRODUCT_SLOTS))
                        issued_next = issued_reg + 1'b1;
                    quiet_next = QUIET_LOAD;
                    if (j_reg == b_count_reg - 1'b1)
                    begin
                        j_next = '0;
                        i_next = i_reg + 1'b1;
                        if (i_reg == a_count_reg - 1'b1)
                            state_next = ST_FLUSH;
                    end
                    else
                    begin
                        j_next = j_reg + 1'b1;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (quiet_reg == '0)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (chain_ent[0].valid)
                begin
                    if (chain_ent[0].coef == '0)
                    begin
                        ctrl.shift = 1'b1;
                    end
                    else if (!pend_have_reg)
                    begin
                        ctrl.shift     = 1'b1;
                        pend_have_next = 1'b1;
                        pend_next      = chain_ent[0];
                    end
                    else if (out_free)
                    begin
                        ctrl.shift     = 1'b1;
                        pend_next      = chain_ent[0];
                        out_v_next     = 1'b1;
                        out_coef_next  = pend_reg.coef;
                        out_exp_next   = pend_reg.expo;
                        out_last_next  = 1'b0;
                        out_empty_next = 1'b0;
                        out_ovf_next   = ovf_reg;
                    end
                end
                else if (out_free)
                begin
                    // row exhausted: final term or the empty marker
                    out_v_next     = 1'b1;
                    out_coef_next  = pend_have_reg ? pend_reg.coef : '0;
                    out_exp_next   = pend_have_reg ? pend_reg.expo : '0;
                    out_last_next  = 1'b1;
                    out_empty_next = !pend_have_reg;
                    out_ovf_next   = ovf_reg;
                    pend_have_next = 1'b0;
                    a_count_next   = '0;
                    b_count_next   = '0;
                    ovf_next       = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_count_reg   <= '0;
            b_count_reg   <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            issued_reg    <= '0;
            quiet_reg     <= '0;
            ovf_reg       <= 1'b0;
            mul_v_reg     <= 1'b0;
            mul_nos_reg   <= 1'b0;
            pend_have_reg <= 1'b0;
            out_v_reg     <= 1'b0;
        end
        else
        begin
            a_count_reg   <= a_count_next;
            b_count_reg   <= b_count_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            issued_reg    <= issued_next;
            quiet_reg     <= quiet_next;
            ovf_reg       <= ovf_next;
            mul_v_reg     <= mul_v_next;
            mul_nos_reg   <= mul_nos_next;
            pend_have_reg <= pend_have_next;
            out_v_reg     <= out_v_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pend_reg      <= pend_next;
        out_coef_reg  <= out_coef_next;
        out_exp_reg   <= out_exp_next;
        out_last_reg  <= out_last_next;
        out_empty_reg <= out_empty_next;
        out_ovf_reg   <= out_ovf_next;
        if (do_issue)
        begin
            mul_p_reg <= $signed(a_coefs_reg[i_reg[IA-1:0]]) *
                         $signed(b_coefs_reg[j_reg[IB-1:0]]);
            mul_e_reg <= PEXP_W'(a_exps_reg[i_reg[IA-1:0]]) +
                         PEXP_W'(b_exps_reg[j_reg[IB-1:0]]);
        end
        if (in_acc && (in_mode == MODE_LOAD_A) && (a_count_reg < CA'(MAX_TERMS_A)))
        begin
            a_coefs_reg[a_count_reg[IA-1:0]] <= in_coef;
            a_exps_reg[a_count_reg[IA-1:0]]  <= in_exp;
        end
        if (in_acc && (in_mode == MODE_LOAD_B) && (b_count_reg < CB'(MAX_TERMS_B)))
        begin
            b_coefs_reg[b_count_reg[IB-1:0]] <= in_coef;
            b_exps_reg[b_count_reg[IB-1:0]]  <= in_exp;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {5'd0, out_exp_reg, out_coef_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = {out_ovf_reg, out_empty_reg};

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks the sparse polynomial multiplier against a behavioural predictor
// ----------------------------------------------------------------------------
// loads and starts are sent over the slave stream in bursts with random gaps;
// every start is predicted in the testbench (pair products summed per
// exponent, zeros removed, descending exponent) and each emitted item is
// compared field by field with the oldest expected item
// ----------------------------------------------------------------------------
module testbench;
    import spm_pkg::*;

    typedef struct packed {
        logic [COEF_W-1:0] coef;
        logic [PEXP_W-1:0] expo;
        logic              last;
        logic              empty;
        logic              ovf;
    } term_out_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic        m_tlast;
    logic [1:0]  m_tuser;

    // predictor state
    logic signed [15:0] a_coef [8];
    logic [9:0]         a_exp  [8];
    int                 a_num;
    logic signed [15:0] b_coef [8];
    logic [9:0]         b_exp  [8];
    int                 b_num;
    logic               dropped;

    term_out_t expected_terms [$];
    int  errors = 0;
    int  cycles = 0;
    int  burst_left = 0;
    int  stall_mode = 0;

    sparse_polynomial_multiplier_core DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser)
    );

    always #2 clk = ~clk;

    // overall guard against a hung block
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 1500000)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // predict the product emitted on a start item
    task automatic predict_product();
        logic [COEF_W-1:0] pc [PRODUCT_SLOTS];
        logic [PEXP_W-1:0] pe [PRODUCT_SLOTS];
        int n;
        int pos;
        int kept;
        logic [PEXP_W-1:0] e;
        logic signed [31:0] p;
        logic [COEF_W-1:0] pw;
        term_out_t t;
        n = 0;
        for (int i = 0; i < a_num; i++)
            for (int j = 0; j < b_num; j++)
            begin
                p = a_coef[i] * b_coef[j];
                pw = {{(COEF_W-32){p[31]}}, p};
                e = {1'b0, a_exp[i]} + {1'b0, b_exp[j]};
                pos = 0;
                while (pos < n && pe[pos] > e)
                    pos++;
                if (pos < n && pe[pos] == e)
                    pc[pos] = pc[pos] + pw;
                else if (n >= PRODUCT_SLOTS)
                    dropped = 1'b1;
                else
                begin
                    for (int k = n; k > pos; k--)
                    begin
                        pc[k] = pc[k-1];
                        pe[k] = pe[k-1];
                    end
                    pc[pos] = pw;
                    pe[pos] = e;
                    n++;
                end
            end
        kept = 0;
        for (int i = 0; i < n; i++)
            if (pc[i] != '0)
            begin
                pc[kept] = pc[i];
                pe[kept] = pe[i];
                kept++;
            end
        if (kept == 0)
        begin
            t = '{coef: '0, expo: '0, last: 1'b1, empty: 1'b1, ovf: dropped};
            expected_terms.push_back(t);
        end
        for (int i = 0; i < kept; i++)
        begin
            t = '{coef: pc[i], expo: pe[i], last: (i == kept - 1), empty: 1'b0, ovf: dropped};
            expected_terms.push_back(t);
        end
        a_num = 0;
        b_num = 0;
        dropped = 1'b0;
    endtask

    // send one item, honouring the burst and gap pattern
    task automatic send_item(input logic [1:0] mode, input logic [15:0] coef,
                             input logic [9:0] expo);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 4);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        s_tuser  <= mode;
        s_tdata  <= {6'd0, expo, coef};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        burst_left--;
        // update the prediction once the item is taken
        if (mode == MODE_LOAD_A)
        begin
            if (a_num < 8)
            begin
                a_coef[a_num] = coef;
                a_exp[a_num] = expo;
                a_num++;
            end
            else
                dropped = 1'b1;
        end
        else if (mode == MODE_LOAD_B)
        begin
            if (b_num < 8)
            begin
                b_coef[b_num] = coef;
                b_exp[b_num] = expo;
                b_num++;
            end
            else
                dropped = 1'b1;
        end
        else if (mode == MODE_START)
            predict_product();
        @(negedge clk);
    endtask

    // receiver stall pattern, changes at the falling edge
    always @(negedge clk)
    begin
        if ($urandom_range(0, 199) == 0)
            stall_mode = $urandom_range(0, 2);
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // result checker
    always @(posedge clk)
    begin
        term_out_t t;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_terms.size() == 0)
            begin
                $error("unexpected result item coef %h", m_tdata[39:0]);
                errors++;
            end
            else
            begin
                t = expected_terms.pop_front();
                if (m_tdata[39:0] !== t.coef)
                begin
                    $error("result_coef expected %h actual %h", t.coef, m_tdata[39:0]);
                    errors++;
                end
                if (m_tdata[50:40] !== t.expo)
                begin
                    $error("result_exponent expected %0d actual %0d", t.expo, m_tdata[50:40]);
                    errors++;
                end
                if (m_tlast !== t.last)
                begin
                    $error("last_term expected %0d actual %0d", t.last, m_tlast);
                    errors++;
                end
                if (m_tuser[0] !== t.empty)
                begin
                    $error("empty_product expected %0d actual %0d", t.empty, m_tuser[0]);
                    errors++;
                end
                if (m_tuser[1] !== t.ovf)
                begin
                    $error("load_overflow expected %0d actual %0d", t.ovf, m_tuser[1]);
                    errors++;
                end
            end
        end
    end

    // sender goes idle until every expected item has come
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(negedge clk);
        while (expected_terms.size() != 0)
            @(negedge clk);
    endtask

    // extremes of the fields, empty products, overflow and cancellation
    task automatic test_directed();
        send_item(MODE_START, 16'h0000, 10'd0);
        send_item(MODE_LOAD_A, 16'h8000, 10'd1023);
        send_item(MODE_LOAD_B, 16'h8000, 10'd1023);
        send_item(MODE_LOAD_A, 16'h7fff, 10'd0);
        send_item(MODE_LOAD_B, 16'h7fff, 10'd0);
        send_item(2'd3, 16'hffff, 10'h3ff);
        send_item(MODE_START, 16'hffff, 10'h3ff);
        // cancelling terms give an empty product
        send_item(MODE_LOAD_A, 16'd1, 10'd5);
        send_item(MODE_LOAD_A, 16'hffff, 10'd5);
        send_item(MODE_LOAD_B, 16'd3, 10'd7);
        send_item(MODE_START, 16'd0, 10'd0);
        // full stores, ninth load dropped
        for (int i = 0; i < 9; i++)
        begin
            send_item(MODE_LOAD_A, 16'(i * 4099 + 1), 10'(i * 113));
            send_item(MODE_LOAD_B, 16'(16'h8000 + i), 10'(1023 - i * 7));
        end
        send_item(MODE_START, 16'd0, 10'd0);
        // pause until all results have come
        wait_drained();
    endtask

    task automatic test_random();
        int na;
        int nb;
        for (int s = 0; s < 40; s++)
        begin
            na = $urandom_range(0, 9);
            nb = $urandom_range(0, 9);
            for (int i = 0; i < na + nb; i++)
                send_item(($urandom_range(0, na + nb - 1) < na) ? MODE_LOAD_A : MODE_LOAD_B,
                          16'($urandom), ($urandom_range(0, 1)) ? 10'($urandom)
                                                                : 10'($urandom_range(0, 7)));
            if ($urandom_range(0, 9) == 0)
                send_item(2'd3, 16'($urandom), 10'($urandom));
            send_item(MODE_START, 16'($urandom), 10'($urandom));
            if ($urandom_range(0, 7) == 0)
                wait_drained();
        end
    endtask

    initial
    begin
        a_num = 0;
        b_num = 0;
        dropped = 1'b0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_random();
        wait_drained();
        repeat (200) @(negedge clk);
        if (errors == 0 && expected_terms.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/spm_pkg.sv
rtl/spm_cell.sv
rtl/sparse_polynomial_multiplier_core.sv
tb/testbench.sv
